// ----- rtl/core/ggs_pkg.sv -----
`default_nettype none

package ggs_pkg;

   // Request kinds carried in req_type.
   localparam logic REQ_SPLAT = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_INV_TWO_SIGMA_SQ = 2'd0;
   localparam logic [1:0] CSR_KERNEL_RADIUS    = 2'd1;
   localparam logic [1:0] CSR_BRIGHTNESS       = 2'd2;

   // Register reset values.
   localparam logic [14:0] RST_INV_TWO_SIGMA_SQ = 15'd2844;
   localparam logic [3:0]  RST_KERNEL_RADIUS    = 4'd3;
   localparam logic [7:0]  RST_BRIGHTNESS       = 8'd255;

   // Color channel codes used by the setup loop.
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // Normalization divisors (channel max times 255) and their half for rounding.
   localparam logic [14:0] DIV_5BIT  = 15'd7905;
   localparam logic [14:0] DIV_6BIT  = 15'd16065;
   localparam logic [28:0] BIAS_5BIT = 29'd3952;
   localparam logic [28:0] BIAS_6BIT = 29'd8032;

   // UQ1.15 one and the RGB565 masks.
   localparam logic [15:0] UNIT_ONE  = 16'd32768;
   localparam logic [7:0]  MASK_5BIT = 8'hF8;
   localparam logic [7:0]  MASK_6BIT = 8'hFC;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_CH_MUL,
      ST_CH_LOAD,
      ST_CH_DIV,
      ST_WIN,
      ST_DY,
      ST_DYL,
      ST_DX,
      ST_K,
      ST_D,
      ST_LOOK,
      ST_MR,
      ST_MG,
      ST_MB,
      ST_WB,
      ST_NEXT,
      ST_RD,
      ST_RD_OUT
   } st_type;

   // Saturate a UQ1.15 channel at one and scale it to eight bits.
   function automatic logic [7:0] to_c8(input logic [15:0] v);
      logic [15:0] x;
      logic [23:0] s;
      x = (v > UNIT_ONE) ? UNIT_ONE : v;
      s = {x, 8'd0} - {8'd0, x};
      return s[22:15];
   endfunction

   // Add with saturation at the full 16-bit range.
   function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Round a UQ2.30 product back to UQ1.15.
   function automatic logic [15:0] round15(input logic [63:0] p);
      logic [31:0] s;
      s = p[31:0] + 32'd16384;
      return s[30:15];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ggs_mul.sv -----
`default_nettype none

module ggs_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic [63:0]      mul_p
);

   logic [63:0] p_ff;
   logic [63:0] p_in;

   // One registered unsigned product, shared by the splat steps of the sequencer.
   assign p_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign mul_p = p_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ggs_div.sv -----
`default_nettype none

module ggs_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [28:0] num,
   input  wire logic [14:0] den,
   output logic             done,
   output logic [15:0]      quo
);

   import ggs_pkg::*;

   // Rounded-up reciprocals of the two normalization divisors. With the shift
   // equal to the numerator width plus the divisor width the quotient is exact
   // for every numerator below 2^29.
   localparam logic [63:0] RECIP_5BIT_FULL =
      ((64'd1 << 42) + 64'(DIV_5BIT) - 64'd1) / 64'(DIV_5BIT);
   localparam logic [63:0] RECIP_6BIT_FULL =
      ((64'd1 << 43) + 64'(DIV_6BIT) - 64'd1) / 64'(DIV_6BIT);
   localparam logic [29:0] RECIP_5BIT = RECIP_5BIT_FULL[29:0];
   localparam logic [29:0] RECIP_6BIT = RECIP_6BIT_FULL[29:0];

   logic        done_ff, done_in;
   logic        sel6_ff, sel6_in;
   logic [58:0] prod_ff, prod_in;
   logic [29:0] recip;

   // Multiply by the reciprocal; the quotient and done are registered, ready in the cycle after start.
   assign sel6_in = (den == DIV_6BIT);
   assign recip   = sel6_in ? RECIP_6BIT : RECIP_5BIT;
   assign prod_in = {30'd0, num} * {29'd0, recip};
   assign done_in = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         sel6_ff <= sel6_in;
      end
   end

   assign done = done_ff;
   assign quo  = sel6_ff ? prod_ff[58:43] : prod_ff[57:42];

endmodule

`default_nettype wire

// ----- rtl/core/ggs_rom.sv -----
`default_nettype none

module ggs_rom #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [$clog2(EXP_TABLE_DEPTH)-1:0] rd_addr,
   output logic [15:0]                             rd_data,
   output logic                                    fill_done
);

   localparam int IW = $clog2(EXP_TABLE_DEPTH);

   // Ratio between neighboring entries, exp(-16/depth) in Q.30, from a
   // truncated thirteen-term series.
   localparam logic [63:0] T0  = 64'd1 << 30;
   localparam logic [63:0] T1  = (T0  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd1);
   localparam logic [63:0] T2  = (T1  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd2);
   localparam logic [63:0] T3  = (T2  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd3);
   localparam logic [63:0] T4  = (T3  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd4);
   localparam logic [63:0] T5  = (T4  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd5);
   localparam logic [63:0] T6  = (T5  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd6);
   localparam logic [63:0] T7  = (T6  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd7);
   localparam logic [63:0] T8  = (T7  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd8);
   localparam logic [63:0] T9  = (T8  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd9);
   localparam logic [63:0] T10 = (T9  * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd10);
   localparam logic [63:0] T11 = (T10 * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd11);
   localparam logic [63:0] T12 = (T11 * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'd12);
   localparam logic [63:0] QSUM = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                                  + T10 - T11 + T12;
   localparam logic [29:0] Q = QSUM[29:0];

   logic [15:0] mem [EXP_TABLE_DEPTH];
   logic [15:0] rd_data_ff;
   logic [IW:0] cnt_ff, cnt_in;
   logic [30:0] e_ff, e_in;
   logic [60:0] e_prod;
   logic [31:0] e_rnd;
   logic        filling;

   // After reset the table is built one entry a cycle by repeated scaling.
   assign filling = cnt_ff < (IW+1)'(EXP_TABLE_DEPTH);
   assign e_prod  = {30'd0, e_ff} * {31'd0, Q};
   assign e_rnd   = {1'b0, e_ff} + 32'd16384;
   assign e_in    = filling ? e_prod[60:30] : e_ff;
   assign cnt_in  = filling ? cnt_ff + (IW+1)'(1) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         e_ff   <= 31'd1 << 30;
      end else begin
         cnt_ff <= cnt_in;
         e_ff   <= e_in;
      end
   end

   // Table write during the build and registered read.
   always_ff @(posedge clock) begin
      if (filling) begin
         mem[cnt_ff[IW-1:0]] <= e_rnd[30:15];
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data   = rd_data_ff;
   assign fill_done = !filling;

endmodule

`default_nettype wire

// ----- rtl/core/ggs_frame.sv -----
`default_nettype none

module ggs_frame #(
   parameter int PIXELS = 2048
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(PIXELS)-1:0] rd_addr,
   output logic [47:0]                    rd_data,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(PIXELS)-1:0] wr_addr,
   input  wire logic [47:0]               wr_data,
   output logic                           clear_done
);

   localparam int AW = $clog2(PIXELS);

   logic [47:0] mem [PIXELS];
   logic [47:0] rd_data_ff;
   logic [AW:0] clr_ff, clr_in;
   logic        clearing;
   logic        we;
   logic [AW-1:0] wa;
   logic [47:0]   wd;

   // Clearing pass after reset: one pixel a cycle, all three channels at once.
   assign clearing = clr_ff < (AW+1)'(PIXELS);
   assign clr_in   = clearing ? clr_ff + (AW+1)'(1) : clr_ff;
   assign we       = clearing | wr_en;
   assign wa       = clearing ? clr_ff[AW-1:0] : wr_addr;
   assign wd       = clearing ? 48'd0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Pixel store, packed red, green, blue; read data is held between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = !clearing;

endmodule

`default_nettype wire

// ----- rtl/core/gaussian_glow_splat_accumulator.sv -----
`default_nettype none

// Gaussian glow splat accumulator.
// Input beats arrive on req_* with req_valid/req_stall. A splat beat (req_type 0)
// adds a gaussian footprint of req_point_color, scaled by brightness, into a
// three-channel frame store and returns nothing. A read beat (req_type 1)
// returns one rsp beat with the pixel saturated and packed as RGB565, then
// clears that pixel; a read outside the frame returns zero.
// The user must write registers on the csr_* port while idle; not enforced here.
// One item at a time: req_stall stays high from acceptance until the item's
// work ends. A splat runs the color setup (per channel a multiply, then a
// reciprocal multiply by the normalizing constant), the window setup, and per
// window pixel the steps DX (at a row start DY and DYL instead), K, D, LOOK,
// MR, MG, MB, WB and NEXT; a pixel past the table skips from LOOK to NEXT. The
// shared multiplier sets the pixel cost. A read reads the frame store, then
// loads the response register and returns to idle, where the next beat is taken.
// The response sits in an output register; a read waits there only while an
// earlier response is still stalled by rsp_stall.
// After reset the frame store is cleared over all FRAME_WIDTH*FRAME_HEIGHT
// pixels (2048 by default) and the exponent table built over all its
// EXP_TABLE_DEPTH entries; req_stall is high during that time.
module gaussian_glow_splat_accumulator #(
   parameter int FRAME_WIDTH     = 64,
   parameter int FRAME_HEIGHT    = 32,
   parameter int MAX_RADIUS      = 8,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [12:0] req_pos_x,
   input  wire logic [12:0] req_pos_y,
   input  wire logic [15:0] req_point_color,
   input  wire logic [5:0]  req_pixel_x,
   input  wire logic [4:0]  req_pixel_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pixel_color,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   import ggs_pkg::*;

   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW     = $clog2(PIXELS);
   localparam int IW     = $clog2(EXP_TABLE_DEPTH);
   localparam logic signed [10:0] XMAX = 11'(FRAME_WIDTH - 1);
   localparam logic signed [10:0] YMAX = 11'(FRAME_HEIGHT - 1);
   localparam logic [4:0] RMAX = 5'(MAX_RADIUS);

   st_type state_ff, state_in;

   // Configuration registers.
   logic [14:0] k_ff;
   logic [3:0]  rad_ff;
   logic [7:0]  bri_ff;

   // Latched request and working registers.
   logic [1:0]  ch_ff, ch_in;
   logic [12:0] posx_ff, posy_ff;
   logic [15:0] color_ff;
   logic [5:0]  pixx_ff;
   logic [4:0]  pixy_ff;
   logic [15:0] red_ff, red_in, grn_ff, grn_in, blu_ff, blu_in;
   logic [XW-1:0] x_ff, x_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0] y_ff, y_in, y1_ff, y1_in;
   logic [15:0] dy2_ff, dy2_in;
   logic [15:0] ctr_ff, ctr_in, ctg_ff, ctg_in;
   logic [15:0] w_ff, w_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_color_ff, rsp_color_in;

   logic        req_take;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        div_start, div_done;
   logic [28:0] div_num;
   logic [14:0] div_den;
   logic [15:0] div_quo;
   logic [IW-1:0] rom_addr;
   logic [15:0] rom_data;
   logic        rom_ready, frame_ready;
   logic        fr_rd_en, fr_wr_en;
   logic [AW-1:0] fr_rd_addr, fr_wr_addr, pix_addr, rd_cell;
   logic [47:0] fr_rd_data, fr_wr_data;

   logic [5:0]  ch_val;
   logic [4:0]  radius;
   logic [12:0] posx_u, posy_u;
   logic [13:0] posx_c, posy_c;
   logic signed [10:0] x0s, x1s, y0s, y1s, x0c, x1c, y0c, y1c;
   logic        win_empty;
   logic signed [13:0] dx, dy;
   logic [7:0]  adx, ady;
   logic [15:0] dist2;
   logic [40:0] idx_full;
   logic [17:0] idx_wide;
   logic        idx_ok;
   logic [8:0]  px9, py9;
   logic        rd_oob;
   logic        out_free;
   logic        last_x, last_y;
   logic [7:0]  rd_r8, rd_g8, rd_b8;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Channel field and the clamped radius.
   always_comb begin
      unique case (ch_ff)
         CH_RED:   ch_val = {1'b0, color_ff[15:11]};
         CH_GREEN: ch_val = color_ff[10:5];
         default:  ch_val = {1'b0, color_ff[4:0]};
      endcase
   end
   assign radius = ({1'b0, rad_ff} > RMAX) ? RMAX : {1'b0, rad_ff};

   // Window bounds: floor and ceiling of the position, widened and clipped.
   assign posx_u = {~posx_ff[12], posx_ff[11:0]};
   assign posy_u = {~posy_ff[12], posy_ff[11:0]};
   assign posx_c = {1'b0, posx_u} + 14'd15;
   assign posy_c = {1'b0, posy_u} + 14'd15;
   assign x0s = $signed({2'd0, posx_u[12:4]}) - 11'sd256 - $signed({6'd0, radius});
   assign x1s = $signed({1'b0, posx_c[13:4]}) - 11'sd256 + $signed({6'd0, radius});
   assign y0s = $signed({2'd0, posy_u[12:4]}) - 11'sd256 - $signed({6'd0, radius});
   assign y1s = $signed({1'b0, posy_c[13:4]}) - 11'sd256 + $signed({6'd0, radius});
   assign x0c = (x0s < 11'sd0) ? 11'sd0 : x0s;
   assign y0c = (y0s < 11'sd0) ? 11'sd0 : y0s;
   assign x1c = (x1s > XMAX) ? XMAX : x1s;
   assign y1c = (y1s > YMAX) ? YMAX : y1s;
   assign win_empty = (x0c > x1c) || (y0c > y1c);

   // Offsets from the point in sixteenths of a pixel; inside the window they
   // stay below 144 in magnitude.
   assign dx  = $signed({1'b0, 13'(x_ff) << 4}) - $signed({posx_ff[12], posx_ff});
   assign dy  = $signed({1'b0, 13'(y_ff) << 4}) - $signed({posy_ff[12], posy_ff});
   assign adx = dx[13] ? 8'(-dx) : dx[7:0];
   assign ady = dy[13] ? 8'(-dy) : dy[7:0];
   assign dist2 = mul_p[15:0] + dy2_ff;

   // Table index, rounded; past the end the weight is zero.
   assign idx_full = mul_p[40:0] + 41'd4194304;
   assign idx_wide = idx_full[40:23];
   assign idx_ok   = idx_wide < 18'(EXP_TABLE_DEPTH);
   assign rom_addr = idx_wide[IW-1:0];

   assign pix_addr = AW'(y_ff * FRAME_WIDTH) + AW'(x_ff);
   assign px9    = {3'd0, pixx_ff};
   assign py9    = {4'd0, pixy_ff};
   assign rd_oob = (px9 >= 9'(FRAME_WIDTH)) || (py9 >= 9'(FRAME_HEIGHT));
   assign rd_cell = AW'(py9[YW-1:0] * FRAME_WIDTH) + AW'(px9[XW-1:0]);
   assign last_x = (x_ff == x1_ff);
   assign last_y = (y_ff == y1_ff);

   // Read pixel channels saturated and scaled to eight bits.
   assign rd_r8 = to_c8(fr_rd_data[47:32]);
   assign rd_g8 = to_c8(fr_rd_data[31:16]);
   assign rd_b8 = to_c8(fr_rd_data[15:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:    if (rom_ready && frame_ready) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_type == REQ_READ) ? ST_RD : ST_CH_MUL;
            end
         end
         ST_CH_MUL:  state_in = ST_CH_LOAD;
         ST_CH_LOAD: state_in = ST_CH_DIV;
         ST_CH_DIV: begin
            if (div_done) state_in = (ch_ff == CH_BLUE) ? ST_WIN : ST_CH_MUL;
         end
         ST_WIN:     state_in = win_empty ? ST_IDLE : ST_DY;
         ST_DY:      state_in = ST_DYL;
         ST_DYL:     state_in = ST_K;
         ST_DX:      state_in = ST_K;
         ST_K:       state_in = ST_D;
         ST_D:       state_in = ST_LOOK;
         ST_LOOK:    state_in = idx_ok ? ST_MR : ST_NEXT;
         ST_MR:      state_in = ST_MG;
         ST_MG:      state_in = ST_MB;
         ST_MB:      state_in = ST_WB;
         ST_WB:      state_in = ST_NEXT;
         ST_NEXT: begin
            priority if (!last_x) state_in = ST_DX;
            else if (!last_y)     state_in = ST_DY;
            else                  state_in = ST_IDLE;
         end
         ST_RD:      state_in = ST_RD_OUT;
         ST_RD_OUT:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_INIT;
      endcase
   end

   // Datapath controls and register updates for each step.
   always_comb begin
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      div_start    = 1'b0;
      div_num      = 29'd0;
      div_den      = DIV_5BIT;
      fr_rd_en     = 1'b0;
      fr_rd_addr   = pix_addr;
      fr_wr_en     = 1'b0;
      fr_wr_addr   = pix_addr;
      fr_wr_data   = 48'd0;
      ch_in        = ch_ff;
      red_in       = red_ff;
      grn_in       = grn_ff;
      blu_in       = blu_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      dy2_in       = dy2_ff;
      ctr_in       = ctr_ff;
      ctg_in       = ctg_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_color_in = rsp_color_ff;
      unique case (state_ff)
         ST_IDLE: ch_in = CH_RED;
         ST_CH_MUL: begin
            mul_a = {26'd0, ch_val};
            mul_b = {24'd0, bri_ff};
         end
         ST_CH_LOAD: begin
            div_start = 1'b1;
            if (ch_ff == CH_GREEN) begin
               div_num = {mul_p[13:0], 15'd0} + BIAS_6BIT;
               div_den = DIV_6BIT;
            end else begin
               div_num = {mul_p[13:0], 15'd0} + BIAS_5BIT;
               div_den = DIV_5BIT;
            end
         end
         ST_CH_DIV: begin
            if (div_done) begin
               unique case (ch_ff)
                  CH_RED:   red_in = div_quo;
                  CH_GREEN: grn_in = div_quo;
                  default:  blu_in = div_quo;
               endcase
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_WIN: begin
            x0_in = x0c[XW-1:0];
            x1_in = x1c[XW-1:0];
            y1_in = y1c[YW-1:0];
            x_in  = x0c[XW-1:0];
            y_in  = y0c[YW-1:0];
         end
         ST_DY: begin
            mul_a = {24'd0, ady};
            mul_b = {24'd0, ady};
         end
         ST_DYL: begin
            dy2_in = mul_p[15:0];
            mul_a  = {24'd0, adx};
            mul_b  = {24'd0, adx};
         end
         ST_DX: begin
            mul_a = {24'd0, adx};
            mul_b = {24'd0, adx};
         end
         ST_K: begin
            mul_a = {16'd0, dist2};
            mul_b = {17'd0, k_ff};
         end
         ST_D: begin
            mul_a = {1'b0, mul_p[30:0]};
            mul_b = 32'(EXP_TABLE_DEPTH);
         end
         ST_LOOK: fr_rd_en = idx_ok;
         // The table output follows its address, so the weight is kept here.
         ST_MR: begin
            w_in  = rom_data;
            mul_a = {16'd0, red_ff};
            mul_b = {16'd0, rom_data};
         end
         ST_MG: begin
            ctr_in = round15(mul_p);
            mul_a  = {16'd0, grn_ff};
            mul_b  = {16'd0, w_ff};
         end
         ST_MB: begin
            ctg_in = round15(mul_p);
            mul_a  = {16'd0, blu_ff};
            mul_b  = {16'd0, w_ff};
         end
         ST_WB: begin
            fr_wr_en   = 1'b1;
            fr_wr_data = {add_sat(fr_rd_data[47:32], ctr_ff),
                          add_sat(fr_rd_data[31:16], ctg_ff),
                          add_sat(fr_rd_data[15:0], round15(mul_p))};
         end
         ST_NEXT: begin
            if (!last_x) begin
               x_in = x_ff + XW'(1);
            end else begin
               x_in = x0_ff;
               y_in = y_ff + YW'(1);
            end
         end
         ST_RD: begin
            fr_rd_en   = !rd_oob;
            fr_rd_addr = rd_cell;
         end
         ST_RD_OUT: begin
            fr_wr_addr = rd_cell;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (rd_oob) begin
                  rsp_color_in = 16'd0;
               end else begin
                  fr_wr_en     = 1'b1;
                  rsp_color_in = {rd_r8 & MASK_5BIT, 8'd0} |
                                 {5'd0, rd_g8 & MASK_6BIT, 3'd0} |
                                 {11'd0, rd_b8[7:3]};
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         k_ff         <= RST_INV_TWO_SIGMA_SQ;
         rad_ff       <= RST_KERNEL_RADIUS;
         bri_ff       <= RST_BRIGHTNESS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_INV_TWO_SIGMA_SQ: k_ff   <= csr_wdata;
               CSR_KERNEL_RADIUS:    rad_ff <= csr_wdata[3:0];
               CSR_BRIGHTNESS:       bri_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         posx_ff  <= req_pos_x;
         posy_ff  <= req_pos_y;
         color_ff <= req_point_color;
         pixx_ff  <= req_pixel_x;
         pixy_ff  <= req_pixel_y;
      end
      ch_ff        <= ch_in;
      red_ff       <= red_in;
      grn_ff       <= grn_in;
      blu_ff       <= blu_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      dy2_ff       <= dy2_in;
      ctr_ff       <= ctr_in;
      ctg_ff       <= ctg_in;
      w_ff         <= w_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;

   ggs_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ggs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   ggs_rom #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_rom (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rom_addr),
      .rd_data   (rom_data),
      .fill_done (rom_ready)
   );

   ggs_frame #(
      .PIXELS (PIXELS)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (fr_rd_en),
      .rd_addr    (fr_rd_addr),
      .rd_data    (fr_rd_data),
      .wr_en      (fr_wr_en),
      .wr_addr    (fr_wr_addr),
      .wr_data    (fr_wr_data),
      .clear_done (frame_ready)
   );

endmodule

`default_nettype wire
